// ===== rtl/cmms_pkg.sv =====
// shared widths, word types and sequencer states of the channel statistics unit
package cmms_pkg;

	localparam int SAMPLE_W  = 8;
	localparam int TALLY_W   = 25;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int AVG_W     = 16;
	localparam int DEV_W     = 15;

	localparam int MEAN_FRAC = 8;
	localparam int VAR_FRAC  = 2 * MEAN_FRAC;

	localparam int ACC_W     = 66;
	localparam int OPR_W     = 32;
	localparam int DIVR_W    = 2 * (TALLY_W - 1) + 1;

	localparam int AVG_STEPS  = AVG_W;
	localparam int NSQ_STEPS  = TALLY_W;
	localparam int SQA_STEPS  = TALLY_W;
	localparam int SQB_STEPS  = SUM_W;
	localparam int DEV_STEPS  = OPR_W;
	localparam int ROOT_STEPS = OPR_W / 2;
	localparam int CNT_W      = $clog2(OPR_W + 1);

	localparam int unsigned MAX_SAMPLES_DEF = 16777216;
	localparam int unsigned SAMPLE_BITS_DEF = 8;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                final_req;
	} cmms_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] minimum;
		logic [SAMPLE_W-1:0] maximum;
		logic [AVG_W-1:0]    average;
		logic [DEV_W-1:0]    deviation;
		logic [TALLY_W-1:0]  sample_count;
	} cmms_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_LOAD,
		ST_AVG_DIV,
		ST_NSQ_LOAD,
		ST_NSQ_MUL,
		ST_SQA_LOAD,
		ST_SQA_MUL,
		ST_SQB_LOAD,
		ST_SQB_MUL,
		ST_DEV_LOAD,
		ST_DEV_DIV,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_DONE
	} cmms_state_t;

endpackage

// ===== rtl/cmms_chan_if.sv =====
// valid/ready channel that carries one word of a given payload type
interface cmms_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/channel_min_max_mean_std_unit.sv =====
// per-channel min, max, count, mean and standard deviation over a sample stream
//
//  channel   dir  payload                                          accepted when
//  samples   in   sample, final_req                                valid && ready
//  results   out  minimum, maximum, average, deviation, count      valid && ready
//
// a word without final_req keeps the unit idle, so samples stream back to back
// a word with final_req holds ready low until idle: one shared 66-bit add/subtract unit
//   runs the mean and variance divides, three shift multiplies (add, add, subtract) and the root
// a finished result sits in the output register; new samples are taken while it waits
// the last step stalls only when the output register is still full
// reset clears the sample accumulators and the output valid flag; no clearing pass
module channel_min_max_mean_std_unit
	import cmms_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cmms_chan_if.sink   samples,
	cmms_chan_if.source results
);

	localparam int EFF_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		SAMPLE_W'((SAMPLE_W + 1)'(1) << EFF_BITS) - SAMPLE_W'(1);
	localparam logic [TALLY_W-1:0] TALLY_LIMIT = TALLY_W'(MAX_SAMPLES);

	cmms_state_t state_q, state_d;

	logic [TALLY_W-1:0]  tally_q;
	logic [SAMPLE_W-1:0] low_q;
	logic [SAMPLE_W-1:0] high_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sq_q;

	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    mcand_q;
	logic [OPR_W-1:0]    mplr_q;
	logic [DIVR_W-1:0]   m_q;
	logic [AVG_W-1:0]    avg_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	cmms_out_t           out_q;

	logic                take;
	logic                room;
	logic [SAMPLE_W-1:0] smp;
	logic [2*SAMPLE_W-1:0] smp_sq;

	logic [ACC_W-1:0]    opa;
	logic [ACC_W-1:0]    opb;
	logic                do_sub;
	logic [ACC_W-1:0]    unit_res;
	logic                unit_ge;
	logic [DIVR_W:0]     div_t;
	logic                last_step;

	assign take      = samples.valid && samples.ready;
	assign room      = !out_valid_q || results.ready;
	assign smp       = samples.payload.sample & SAMPLE_MASK;
	assign smp_sq    = (2*SAMPLE_W)'(smp) * (2*SAMPLE_W)'(smp);
	assign last_step = (cnt_q == '0);
	assign div_t     = {acc_q[DIVR_W-1:0], mplr_q[OPR_W-1]};

	// shared add/subtract unit
	assign unit_res = do_sub ? (opa - opb) : (opa + opb);
	assign unit_ge  = !unit_res[ACC_W-1];

	assign samples.ready   = (state_q == ST_IDLE);
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (take && samples.payload.final_req) state_d = ST_AVG_LOAD;
			ST_AVG_LOAD:  state_d = ST_AVG_DIV;
			ST_AVG_DIV:   if (last_step) state_d = ST_NSQ_LOAD;
			ST_NSQ_LOAD:  state_d = ST_NSQ_MUL;
			ST_NSQ_MUL:   if (last_step) state_d = ST_SQA_LOAD;
			ST_SQA_LOAD:  state_d = ST_SQA_MUL;
			ST_SQA_MUL:   if (last_step) state_d = ST_SQB_LOAD;
			ST_SQB_LOAD:  state_d = ST_SQB_MUL;
			ST_SQB_MUL:   if (last_step) state_d = ST_DEV_LOAD;
			ST_DEV_LOAD:  state_d = ST_DEV_DIV;
			ST_DEV_DIV:   if (last_step) state_d = ST_ROOT_LOAD;
			ST_ROOT_LOAD: state_d = ST_ROOT;
			ST_ROOT:      if (last_step) state_d = ST_DONE;
			ST_DONE:      if (room) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		opa    = acc_q;
		opb    = '0;
		do_sub = 1'b0;
		unique case (state_q)
			ST_AVG_DIV, ST_DEV_DIV: begin
				opa    = ACC_W'(div_t);
				opb    = ACC_W'(m_q);
				do_sub = 1'b1;
			end
			ST_NSQ_MUL, ST_SQA_MUL: begin
				opb = mplr_q[0] ? mcand_q : '0;
			end
			ST_SQB_MUL: begin
				opb    = mplr_q[0] ? mcand_q : '0;
				do_sub = 1'b1;
			end
			ST_ROOT: begin
				opb    = mcand_q | ACC_W'(mplr_q);
				do_sub = 1'b1;
			end
			ST_IDLE, ST_AVG_LOAD, ST_NSQ_LOAD, ST_SQA_LOAD, ST_SQB_LOAD,
			ST_DEV_LOAD, ST_ROOT_LOAD, ST_DONE: begin
				opa = acc_q;
			end
		endcase
	end

	// sequencer state, accumulators and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			low_q       <= SAMPLE_MASK;
			high_q      <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && tally_q < TALLY_LIMIT) begin
				tally_q <= tally_q + TALLY_W'(1);
				if (smp < low_q) low_q <= smp;
				if (smp > high_q) high_q <= smp;
				sum_q <= sum_q + SUM_W'(smp);
				sq_q  <= sq_q + SQ_W'(smp_sq);
			end
			if (state_q == ST_DONE && room) begin
				out_valid_q <= 1'b1;
				tally_q     <= '0;
				low_q       <= SAMPLE_MASK;
				high_q      <= '0;
				sum_q       <= '0;
				sq_q        <= '0;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath of the shared unit
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_AVG_LOAD: begin
				acc_q  <= ACC_W'(sum_q[SUM_W-1:MEAN_FRAC]);
				mplr_q <= OPR_W'(sum_q[MEAN_FRAC-1:0]) << (OPR_W - MEAN_FRAC);
				m_q    <= DIVR_W'(tally_q);
				cnt_q  <= CNT_W'(AVG_STEPS - 1);
			end
			ST_AVG_DIV, ST_DEV_DIV: begin
				acc_q  <= unit_ge ? unit_res : ACC_W'(div_t);
				mplr_q <= {mplr_q[OPR_W-2:0], unit_ge};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_NSQ_LOAD: begin
				avg_q   <= mplr_q[AVG_W-1:0];
				acc_q   <= '0;
				mcand_q <= ACC_W'(tally_q);
				mplr_q  <= OPR_W'(tally_q);
				cnt_q   <= CNT_W'(NSQ_STEPS - 1);
			end
			ST_NSQ_MUL, ST_SQA_MUL, ST_SQB_MUL: begin
				acc_q   <= unit_res;
				mcand_q <= {mcand_q[ACC_W-2:0], 1'b0};
				mplr_q  <= {1'b0, mplr_q[OPR_W-1:1]};
				cnt_q   <= cnt_q - CNT_W'(1);
			end
			ST_SQA_LOAD: begin
				m_q     <= acc_q[DIVR_W-1:0];
				acc_q   <= '0;
				mcand_q <= ACC_W'(sq_q);
				mplr_q  <= OPR_W'(tally_q);
				cnt_q   <= CNT_W'(SQA_STEPS - 1);
			end
			ST_SQB_LOAD: begin
				mcand_q <= ACC_W'(sum_q);
				mplr_q  <= OPR_W'(sum_q);
				cnt_q   <= CNT_W'(SQB_STEPS - 1);
			end
			ST_DEV_LOAD: begin
				// negative difference gives a zero deviation
				if (acc_q[ACC_W-1]) begin
					acc_q  <= '0;
					mplr_q <= '0;
				end else begin
					acc_q  <= ACC_W'(acc_q[ACC_W-1:VAR_FRAC]);
					mplr_q <= OPR_W'(acc_q[VAR_FRAC-1:0]) << (OPR_W - VAR_FRAC);
				end
				cnt_q <= CNT_W'(DEV_STEPS - 1);
			end
			ST_ROOT_LOAD: begin
				acc_q   <= ACC_W'(mplr_q);
				mcand_q <= '0;
				mplr_q  <= OPR_W'(1) << (2 * ROOT_STEPS - 2);
				cnt_q   <= CNT_W'(ROOT_STEPS - 1);
			end
			ST_ROOT: begin
				if (unit_ge) begin
					acc_q   <= unit_res;
					mcand_q <= {1'b0, mcand_q[ACC_W-1:1]} | ACC_W'(mplr_q);
				end else begin
					mcand_q <= {1'b0, mcand_q[ACC_W-1:1]};
				end
				mplr_q <= {2'b00, mplr_q[OPR_W-1:2]};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_DONE: begin
				if (room) begin
					out_q.minimum      <= low_q;
					out_q.maximum      <= high_q;
					out_q.average      <= avg_q;
					out_q.deviation    <= mcand_q[DEV_W-1:0];
					out_q.sample_count <= tally_q;
				end
			end
			ST_IDLE: begin
				cnt_q <= '0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_final_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		take && samples.payload.final_req |=> !samples.ready)
		else $error("word accepted right after a final word");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_LIMIT)
		else $error("sample count past its limit");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> $onehot(mplr_q))
		else $error("root trial bit not one-hot");
`endif

endmodule

// ===== sim/tb_channel_min_max_mean_std_unit.sv =====
// testbench for the channel statistics unit: directed and random channels checked against a predictor
`timescale 1ns / 100ps

module tb_channel_min_max_mean_std_unit;
	import cmms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 200;
	localparam int TARGET_WORDS = 950;

	typedef enum {FILL_UNIFORM, FILL_CONST, FILL_EXTREME, FILL_NARROW} fill_mode_t;

	logic clk;
	logic arst_n;

	cmms_chan_if #(.payload_t(cmms_in_t))  samples_ch();
	cmms_chan_if #(.payload_t(cmms_out_t)) results_ch();

	channel_min_max_mean_std_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	cmms_in_t  sample_words[$];
	cmms_out_t stats_due[$];

	logic [TALLY_W-1:0]  ch_count;
	logic [SAMPLE_W-1:0] ch_min;
	logic [SAMPLE_W-1:0] ch_max;
	logic [SUM_W-1:0]    ch_sum;
	logic [SQ_W-1:0]     ch_sumsq;

	int words_in;
	int total_words;
	int send_gap_pct;
	int recv_gap_pct;
	int stall_cycles;
	int errors;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	assign send_gap_pct = (words_in < total_words / 3) ? 9 :
		(words_in < 2 * total_words / 3) ? 50 : 0;
	assign recv_gap_pct = (words_in < total_words / 3) ? 50 :
		(words_in < 2 * total_words / 3) ? 9 : 0;

	function automatic logic [63:0] int_sqrt(input logic [127:0] x);
		logic [63:0]  r;
		logic [127:0] t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = {64'd0, r | (64'd1 << i)};
			if (t * t <= x) begin
				r = r | (64'd1 << i);
			end
		end
		return r;
	endfunction

	function automatic void clear_channel();
		ch_count = '0;
		ch_min   = '1;
		ch_max   = '0;
		ch_sum   = '0;
		ch_sumsq = '0;
	endfunction

	// accumulate one sample, close the channel on the flagged word
	function automatic void take_sample(cmms_in_t w);
		logic [127:0] n;
		logic [127:0] sum;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [127:0] mean;
		logic [127:0] var_q;
		logic [63:0]  root;
		cmms_out_t    res;
		if (ch_count < MAX_SAMPLES_DEF) begin
			ch_count = ch_count + 1'b1;
			if (w.sample < ch_min) begin
				ch_min = w.sample;
			end
			if (w.sample > ch_max) begin
				ch_max = w.sample;
			end
			ch_sum   = ch_sum + w.sample;
			ch_sumsq = ch_sumsq + w.sample * w.sample;
		end
		if (!w.final_req) begin
			return;
		end
		n    = 128'(ch_count);
		sum  = 128'(ch_sum);
		mean = (sum << MEAN_FRAC) / n;
		lhs  = n * 128'(ch_sumsq);
		rhs  = sum * sum;
		if (lhs < rhs) begin
			root = '0;
		end else begin
			var_q = ((lhs - rhs) << VAR_FRAC) / (n * n);
			root  = int_sqrt(var_q);
		end
		res.minimum      = ch_min;
		res.maximum      = ch_max;
		res.average      = mean[AVG_W-1:0];
		res.deviation    = root[DEV_W-1:0];
		res.sample_count = ch_count;
		stats_due.push_back(res);
		clear_channel();
	endfunction

	function automatic void push_word(logic [SAMPLE_W-1:0] s, logic last);
		cmms_in_t w;
		w.sample    = s;
		w.final_req = last;
		sample_words.push_back(w);
	endfunction

	function automatic void add_channel(int len, fill_mode_t mode);
		int base;
		int s;
		base = $urandom_range(255, 0);
		for (int i = 0; i < len; i++) begin
			case (mode)
				FILL_UNIFORM: s = $urandom_range(255, 0);
				FILL_CONST:   s = base;
				FILL_EXTREME: s = $urandom_range(1, 0) ? 255 : 0;
				default: begin
					s = base + $urandom_range(6, 0) - 3;
					if (s < 0) s = 0;
					if (s > 255) s = 255;
				end
			endcase
			push_word(s[SAMPLE_W-1:0], i == len - 1);
		end
	endfunction

	// sample source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_ch.valid   <= 1'b0;
			samples_ch.payload <= '0;
		end else if (!samples_ch.valid || samples_ch.ready) begin
			if (sample_words.size() > 0 && $urandom_range(99, 0) >= send_gap_pct) begin
				samples_ch.valid   <= 1'b1;
				samples_ch.payload <= sample_words.pop_front();
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// result sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= $urandom_range(99, 0) >= recv_gap_pct;
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		cmms_out_t want;
		cmms_out_t got;
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready) begin
				got = results_ch.payload;
				if (stats_due.size() == 0) begin
					$error("unexpected result word: min %0d max %0d count %0d",
						got.minimum, got.maximum, got.sample_count);
					errors++;
				end else begin
					want = stats_due.pop_front();
					if (got.minimum !== want.minimum) begin
						$error("minimum: expected %0d, got %0d", want.minimum, got.minimum);
						errors++;
					end
					if (got.maximum !== want.maximum) begin
						$error("maximum: expected %0d, got %0d", want.maximum, got.maximum);
						errors++;
					end
					if (got.average !== want.average) begin
						$error("average: expected %0d, got %0d", want.average, got.average);
						errors++;
					end
					if (got.deviation !== want.deviation) begin
						$error("deviation: expected %0d, got %0d",
							want.deviation, got.deviation);
						errors++;
					end
					if (got.sample_count !== want.sample_count) begin
						$error("sample_count: expected %0d, got %0d",
							want.sample_count, got.sample_count);
						errors++;
					end
				end
			end
			if (samples_ch.valid && samples_ch.ready) begin
				take_sample(samples_ch.payload);
				words_in <= words_in + 1;
			end
			if ((samples_ch.valid && samples_ch.ready) ||
				(results_ch.valid && results_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int len;
		arst_n             = 1'b0;
		samples_ch.valid   = 1'b0;
		samples_ch.payload = '0;
		results_ch.ready   = 1'b0;
		words_in           = 0;
		stall_cycles       = 0;
		errors             = 0;
		clear_channel();

		// single-sample channels at the extremes and the midpoint
		push_word(8'd0, 1'b1);
		push_word(8'd255, 1'b1);
		push_word(8'd128, 1'b1);
		// widest spread
		push_word(8'd0, 1'b0);
		push_word(8'd255, 1'b1);
		// largest mean
		repeat (4) push_word(8'd255, 1'b0);
		push_word(8'd255, 1'b1);
		for (int i = 0; i < 6; i++) begin
			push_word((i % 2) ? 8'd255 : 8'd0, i == 5);
		end
		// falling minimum, maximum only from the first word
		push_word(8'd200, 1'b0);
		push_word(8'd100, 1'b0);
		push_word(8'd50, 1'b0);
		push_word(8'd1, 1'b1);

		while (sample_words.size() < TARGET_WORDS) begin
			len = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
			if (len > TARGET_WORDS - sample_words.size()) begin
				len = TARGET_WORDS - sample_words.size();
			end
			add_channel(len, fill_mode_t'($urandom_range(3, 0)));
		end
		total_words = sample_words.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sample_words.size() > 0 || samples_ch.valid) @(posedge clk);
		while (stats_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
